// ===== rtl/mcf_pkg.sv =====
// Package for the multichannel FIR filter: opcodes, state codes, word types
// and Q15 constants. No dependencies.
`default_nettype none

package mcf_pkg;

    localparam int TAPS_DEF     = 32;
    localparam int CHANNELS_DEF = 4;

    localparam int Q_SHIFT = 15;
    localparam int SAT_HI  = 32767;
    localparam int SAT_LO  = -32768;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_WEIGHT  = 3'd1,
        OP_READ    = 3'd2,
        OP_CLR_CH  = 3'd3,
        OP_CLR_ALL = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_PUSH,
        ST_MAC,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [1:0]         channel;
        logic [4:0]         tap;
        logic signed [15:0] weight_value;
        logic signed [15:0] sample_ch0;
        logic signed [15:0] sample_ch1;
        logic signed [15:0] sample_ch2;
        logic signed [15:0] sample_ch3;
    } t_fir_in;

    typedef struct packed {
        logic [1:0]         channel_out;
        logic signed [15:0] raw_sample;
        logic signed [15:0] filtered_sample;
    } t_fir_out;

endpackage

`default_nettype wire

// ===== rtl/mcf_if.sv =====
// Valid/ready channel interfaces for the filter's input and result words.
// Depends on mcf_pkg for the word types.
`default_nettype none

interface mcf_in_if
    import mcf_pkg::*;
();
    logic    valid;
    logic    ready;
    t_fir_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mcf_out_if
    import mcf_pkg::*;
();
    logic     valid;
    logic     ready;
    t_fir_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/multichannel_fir_filter_top.sv =====
// Multichannel FIR filter top level: sample and weight memories, one shared MAC.
// Depends on mcf_pkg and the interfaces in mcf_if.sv.
//
// Each word holds the input port until the block is done with it, as there is a
// single memory write port and a single multiply-accumulate unit. A weight write
// is done as the word is accepted. A push writes one history entry per
// channel. A read runs the accepting cycle, one MAC step per tap, then the
// memory read and product registers and the saturating output load; a read of a
// channel beyond CHANNELS returns zeros. A channel clear and a clear-all clear
// one memory entry per cycle. After reset the block runs an initialization pass
// (history zero, tap 0 weights 32767) before it shows ready. A finished result
// sits in an output register, so the next word may be taken while the result
// waits; a read then waits at its end until that register is free.
`default_nettype none

module multichannel_fir_filter_top
    import mcf_pkg::*;
#(
    parameter int TAPS     = TAPS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mcf_in_if.sink      i_in,
    mcf_out_if.source   o_out
);

    localparam int TW     = $clog2(TAPS);
    localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW     = CW + TW;
    localparam int MEM_D  = 1 << AW;
    localparam int ACC_W  = 32 + TW;

    localparam logic [TW-1:0]          SLOT_LAST = TW'(TAPS - 1);
    localparam logic [CW-1:0]          CH_LAST   = CW'(CHANNELS - 1);
    localparam logic signed [ACC_W-1:0] ACC_HI   = ACC_W'(SAT_HI);
    localparam logic signed [ACC_W-1:0] ACC_LO   = ACC_W'(SAT_LO);

    // Memories
    logic signed [15:0] r_hist_mem [MEM_D];
    logic signed [15:0] r_coef_mem [MEM_D];
    logic signed [15:0] r_hist_rd;
    logic signed [15:0] r_coef_rd;

    // Control state
    t_state        r_state, n_state;
    logic [TW-1:0] r_wp;
    logic [CW-1:0] r_sw_ch;
    logic [TW-1:0] r_sw_slot;
    logic          r_sw_all;
    logic          r_sw_coef;
    logic [CW-1:0] r_ch;
    logic [1:0]    r_ch_field;
    logic [TW-1:0] r_k;
    logic [TW-1:0] r_slot;
    logic          r_rd_vld;
    logic          r_rd_first;
    logic          r_prod_vld;
    logic          r_out_vld;

    // Datapath
    logic signed [15:0]      r_smp [4];
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [15:0]      r_raw;
    t_fir_out                r_out;

    // Decoded input
    logic          accept;
    logic          ch_ok;
    logic          tap_ok;
    logic [CW-1:0] in_ch;
    logic [TW-1:0] wp_prev;

    // Memory port controls
    logic               hist_we;
    logic [AW-1:0]      hist_waddr;
    logic signed [15:0] hist_wdata;
    logic               coef_we;
    logic [AW-1:0]      coef_waddr;
    logic signed [15:0] coef_wdata;
    logic               rd_issue;
    logic [AW-1:0]      hist_raddr;
    logic [AW-1:0]      coef_raddr;

    logic                    sweep_done;
    logic                    push_done;
    logic                    mac_done;
    logic                    drain_done;
    logic signed [ACC_W-1:0] acc_q;
    logic signed [15:0]      filt;

    assign accept  = i_in.valid && i_in.ready;
    assign ch_ok   = 32'(i_in.data.channel) < 32'(CHANNELS);
    assign tap_ok  = 32'(i_in.data.tap) < 32'(TAPS);
    assign in_ch   = CW'(i_in.data.channel);
    assign wp_prev = (r_wp == '0) ? SLOT_LAST : r_wp - 1'b1;

    assign sweep_done = (r_sw_slot == SLOT_LAST) && (!r_sw_all || r_sw_ch == CH_LAST);
    assign push_done  = (r_sw_ch == CH_LAST);
    assign mac_done   = (r_k == SLOT_LAST);
    assign drain_done = !r_rd_vld && !r_prod_vld && (!r_out_vld || o_out.ready);

    // Floor shift, then clamp to 16 bits
    assign acc_q = r_acc >>> Q_SHIFT;
    always_comb begin
        if (acc_q > ACC_HI) begin
            filt = 16'(SAT_HI);
        end else if (acc_q < ACC_LO) begin
            filt = 16'(SAT_LO);
        end else begin
            filt = acc_q[15:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: begin
                if (sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_in.data.opcode)
                        OP_PUSH:    n_state = ST_PUSH;
                        OP_READ:    n_state = ch_ok ? ST_MAC : ST_DRAIN;
                        OP_CLR_CH:  n_state = ch_ok ? ST_SWEEP : ST_IDLE;
                        OP_CLR_ALL: n_state = ST_SWEEP;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH: begin
                if (push_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MAC: begin
                if (mac_done) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory ports and input ready
    always_comb begin
        i_in.ready = 1'b0;
        hist_we    = 1'b0;
        hist_waddr = {r_sw_ch, r_sw_slot};
        hist_wdata = '0;
        coef_we    = 1'b0;
        coef_waddr = {r_sw_ch, r_sw_slot};
        coef_wdata = '0;
        rd_issue   = 1'b0;
        hist_raddr = {r_ch, r_slot};
        coef_raddr = {r_ch, r_k};
        unique case (r_state)
            ST_SWEEP: begin
                hist_we = 1'b1;
                coef_we = r_sw_coef;
                coef_wdata = (r_sw_slot == '0) ? 16'(SAT_HI) : '0;
            end
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (accept && i_in.data.opcode == OP_WEIGHT && ch_ok && tap_ok) begin
                    coef_we    = 1'b1;
                    coef_waddr = {in_ch, TW'(i_in.data.tap)};
                    coef_wdata = i_in.data.weight_value;
                end
            end
            ST_PUSH: begin
                hist_we    = 1'b1;
                hist_waddr = {r_sw_ch, r_wp};
                hist_wdata = r_smp[2'(r_sw_ch)];
            end
            ST_MAC: begin
                rd_issue = 1'b1;
            end
            ST_DRAIN: ;
            default: ;
        endcase
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_waddr] <= hist_wdata;
        end
        r_hist_rd <= r_hist_mem[hist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[coef_waddr] <= coef_wdata;
        end
        r_coef_rd <= r_coef_mem[coef_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_SWEEP;
            r_wp       <= '0;
            r_sw_ch    <= '0;
            r_sw_slot  <= '0;
            r_sw_all   <= 1'b1;
            r_sw_coef  <= 1'b1;
            r_k        <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= rd_issue;
            r_rd_first <= rd_issue && (r_k == '0);
            r_prod_vld <= r_rd_vld;

            if (r_state == ST_DRAIN && drain_done) begin
                r_out_vld <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_SWEEP: begin
                    r_sw_slot <= (r_sw_slot == SLOT_LAST) ? '0 : r_sw_slot + 1'b1;
                    if (r_sw_slot == SLOT_LAST) begin
                        r_sw_ch <= r_sw_ch + 1'b1;
                    end
                    if (sweep_done) begin
                        r_sw_coef <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    r_sw_slot <= '0;
                    r_k       <= '0;
                    if (accept) begin
                        case (i_in.data.opcode)
                            OP_PUSH: begin
                                r_sw_ch <= '0;
                            end
                            OP_CLR_CH: begin
                                r_sw_ch  <= in_ch;
                                r_sw_all <= 1'b0;
                            end
                            OP_CLR_ALL: begin
                                r_sw_ch  <= '0;
                                r_sw_all <= 1'b1;
                                r_wp     <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PUSH: begin
                    r_sw_ch <= r_sw_ch + 1'b1;
                    if (push_done) begin
                        r_wp <= (r_wp == SLOT_LAST) ? '0 : r_wp + 1'b1;
                    end
                end
                ST_MAC: begin
                    r_k <= r_k + 1'b1;
                end
                ST_DRAIN: ;
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp[0]   <= i_in.data.sample_ch0;
            r_smp[1]   <= i_in.data.sample_ch1;
            r_smp[2]   <= i_in.data.sample_ch2;
            r_smp[3]   <= i_in.data.sample_ch3;
            r_ch       <= in_ch;
            r_ch_field <= i_in.data.channel;
        end

        // Walk the ring from newest to oldest
        if (accept) begin
            r_slot <= wp_prev;
        end else if (rd_issue) begin
            r_slot <= (r_slot == '0) ? SLOT_LAST : r_slot - 1'b1;
        end

        r_prod <= r_coef_rd * r_hist_rd;

        if (accept) begin
            r_acc <= '0;
            r_raw <= '0;
        end else begin
            if (r_prod_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (r_rd_vld && r_rd_first) begin
                r_raw <= r_hist_rd;
            end
        end

        if (r_state == ST_DRAIN && drain_done) begin
            r_out.channel_out     <= r_ch_field;
            r_out.raw_sample      <= r_raw;
            r_out.filtered_sample <= filt;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire
